// ===== hw/rtl/csm_pkg.sv =====
// Shared types and constants for the contiguous sequence matcher.
package csm_pkg;

    localparam int MAX_PAT_DEF = 16;
    localparam int WORD_W = 32;

    localparam logic REQ_PATTERN = 1'b0;
    localparam logic REQ_TEXT    = 1'b1;

    // Broadcast controls from the top level to every match cell.
    typedef struct packed {
        logic clear;   // Drop the match bit.
        logic shift;   // A text word moves the match bits one cell along.
        logic load;    // A pattern word is written into the addressed cell.
    } t_cell_ctl;

endpackage

// ===== hw/rtl/csm_cell.sv =====
// One pattern position: its stored word and its shift-and match bit.
module csm_cell
    import csm_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int LEN_W = 5
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_ctl                i_ctl,
    input  logic [LEN_W-1:0]         i_len,
    input  logic [LEN_W-1:0]         i_wr_idx,
    input  logic signed [WORD_W-1:0] i_word,
    input  logic                     i_match,
    output logic                     o_match,
    output logic                     o_hit
);

    logic signed [WORD_W-1:0] r_word;
    logic                     r_match;
    logic                     n_match;
    logic                     active;
    logic                     tail;
    logic                     step;

    assign active = LEN_W'(IDX) < i_len;
    assign tail   = (LEN_W'(IDX + 1) == i_len);
    assign step   = i_match && (r_word == i_word);

    always_comb begin
        n_match = r_match;
        if (i_ctl.clear) begin
            n_match = 1'b0;
        end else if (i_ctl.shift && active) begin
            n_match = step;
        end
    end

    // The last active cell reports a completed run in the cycle it forms.
    assign o_hit   = i_ctl.shift && tail && step;
    assign o_match = r_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else begin
            r_match <= n_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && (i_wr_idx == LEN_W'(IDX))) begin
            r_word <= i_word;
        end
    end

endmodule

// ===== hw/rtl/contiguous_sequence_matcher.sv =====
// Top level of the contiguous sequence matcher: control, cell chain and result register.
//
// The block tells whether a pattern of signed 32-bit words occurs as a contiguous
// run inside a text. Pattern words (req_type 0) are written one per word into a
// chain of MAX_PAT cells; the word marked last closes the pattern, and the next
// pattern word starts a new one. Text words (req_type 1) move a shift-and match bit
// along the chain, every cell comparing its stored word in parallel, so one word is
// taken in every cycle unless a text end must wait. The text word marked last produces
// exactly one result word in the next cycle: found, and pattern_overflow when the
// pattern had more than MAX_PAT words (found is then 0). An empty pattern always
// matches; an empty text against a non-empty pattern does not. Words that end a text
// wait only while an earlier result is still held in the output register; every other
// word is accepted regardless of the output side. Any pattern word clears a text
// search in progress. The critical path is one 32-bit compare per cell plus the OR
// of the cell hit flags.
module contiguous_sequence_matcher
    import csm_pkg::*;
#(
    parameter int MAX_PAT = MAX_PAT_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_req_type,
    input  logic                     i_has_value,
    input  logic signed [WORD_W-1:0] i_element_value,
    input  logic                     i_is_last,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_found,
    output logic                     o_pattern_overflow
);

    localparam int LEN_W = $clog2(MAX_PAT + 1);

    logic [LEN_W-1:0] r_len,  n_len;
    logic             r_closed, n_closed;
    logic             r_ovf,  n_ovf;
    logic             r_found, n_found;
    logic             r_out_valid, n_out_valid;
    logic             r_out_found, n_out_found;
    logic             r_out_ovf,   n_out_ovf;

    logic             accept;
    logic             is_pat;
    logic             ends_text;
    logic [LEN_W-1:0] eff_len;
    logic             eff_ovf;
    logic             hit_now;
    t_cell_ctl        ctl;
    logic [MAX_PAT:0] match_chain;
    logic [MAX_PAT-1:0] hits;

    assign is_pat    = (i_req_type == REQ_PATTERN);
    assign ends_text = (i_req_type == REQ_TEXT) && i_is_last;

    // Only a word that produces a result must wait for the output register.
    assign o_ready = !r_out_valid || i_ready || !ends_text;
    assign accept  = i_valid && o_ready;

    // A pattern word arriving after a closed pattern starts a fresh one.
    assign eff_len = r_closed ? '0 : r_len;
    assign eff_ovf = r_closed ? 1'b0 : r_ovf;

    always_comb begin
        ctl.load  = accept && is_pat && i_has_value && (eff_len < LEN_W'(MAX_PAT));
        ctl.shift = accept && !is_pat && i_has_value && (r_len != '0);
        ctl.clear = accept && (is_pat || i_is_last);
    end

    assign match_chain[0] = 1'b1;

    for (genvar g = 0; g < MAX_PAT; g++) begin : g_cell
        csm_cell #(
            .IDX   (g),
            .LEN_W (LEN_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_len    (r_len),
            .i_wr_idx (eff_len),
            .i_word   (i_element_value),
            .i_match  (match_chain[g]),
            .o_match  (match_chain[g+1]),
            .o_hit    (hits[g])
        );
    end

    assign hit_now = |hits;

    always_comb begin
        n_len       = r_len;
        n_closed    = r_closed;
        n_ovf       = r_ovf;
        n_found     = r_found;
        n_out_valid = r_out_valid && !i_ready;
        n_out_found = r_out_found;
        n_out_ovf   = r_out_ovf;
        if (accept) begin
            if (is_pat) begin
                n_len = eff_len;
                n_ovf = eff_ovf;
                if (i_has_value) begin
                    if (eff_len < LEN_W'(MAX_PAT)) begin
                        n_len = eff_len + LEN_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                n_closed = r_closed ? i_is_last : (r_closed || i_is_last);
                n_found  = 1'b0;
            end else begin
                if (hit_now) begin
                    n_found = 1'b1;
                end
                if (i_is_last) begin
                    n_out_valid = 1'b1;
                    n_out_ovf   = r_ovf;
                    if (r_ovf) begin
                        n_out_found = 1'b0;
                    end else if (r_len == '0) begin
                        n_out_found = 1'b1;
                    end else begin
                        n_out_found = r_found || hit_now;
                    end
                    n_found = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_closed    <= 1'b1;
            r_ovf       <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_closed    <= n_closed;
            r_ovf       <= n_ovf;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_found <= n_out_found;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_valid            = r_out_valid;
    assign o_found            = r_out_found;
    assign o_pattern_overflow = r_out_ovf;

    a_len_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(MAX_PAT))
        else $error("pattern length beyond capacity");

    a_ovf_not_found : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ovf) |-> !r_out_found)
        else $error("overflowed pattern reported as found");

    a_text_end_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ends_text) |=> r_out_valid)
        else $error("text end gave no result");

    a_pattern_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_pat) |=> (match_chain[MAX_PAT:1] == '0 && !r_found))
        else $error("pattern word left search state behind");

endmodule

// ===== sim/tb_contiguous_sequence_matcher.sv =====
// Testbench for the contiguous sequence matcher: random handshakes, a search predictor and checks.
`timescale 1ns / 100ps

module tb_contiguous_sequence_matcher;
    import csm_pkg::*;

    localparam int MAX_PAT      = MAX_PAT_DEF;
    localparam int RANDOM_WORDS = 850;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int REPORT_MAX   = 10;

    typedef logic [WORD_W-1:0] t_word;

    // One result word as the block should deliver it.
    typedef struct packed {
        logic found;
        logic overflow;
    } t_verdict;

    // Tracks the pattern store and the shift-and search exactly as the block
    // should, and queues the verdict that every text end must produce.
    class t_search_verdict_model;
        t_word              pat_mem[MAX_PAT];
        int                 pat_len;
        bit                 pat_closed;
        bit                 pat_overflow;
        logic [MAX_PAT-1:0] run_bits;
        bit                 hit_seen;
        t_verdict           pending[$];
        int                 err_cnt;

        function new();
            pat_len      = 0;
            pat_closed   = 1'b1;
            pat_overflow = 1'b0;
            run_bits     = '0;
            hit_seen     = 1'b0;
            err_cnt      = 0;
        endfunction

        // Called for every word that the block accepts.
        function void take_word(logic req, logic has_val, t_word w, logic last);
            t_verdict v;
            if (req == REQ_PATTERN) begin
                // The first pattern word after a closed pattern starts a new one.
                if (pat_closed) begin
                    pat_len      = 0;
                    pat_overflow = 1'b0;
                    pat_closed   = 1'b0;
                end
                if (has_val) begin
                    if (pat_len < MAX_PAT) begin
                        pat_mem[pat_len] = w;
                        pat_len++;
                    end else begin
                        pat_overflow = 1'b1;
                    end
                end
                if (last) begin
                    pat_closed = 1'b1;
                end
                // Any pattern word restarts a text search in progress.
                run_bits = '0;
                hit_seen = 1'b0;
                return;
            end
            if (has_val && pat_len > 0) begin
                for (int i = pat_len - 1; i > 0; i--) begin
                    run_bits[i] = run_bits[i-1] && (pat_mem[i] == w);
                end
                run_bits[0] = (pat_mem[0] == w);
                if (run_bits[pat_len-1]) begin
                    hit_seen = 1'b1;
                end
            end
            if (last) begin
                v.overflow = pat_overflow;
                v.found    = !pat_overflow && (pat_len == 0 || hit_seen);
                pending.push_back(v);
                run_bits = '0;
                hit_seen = 1'b0;
            end
        endfunction

        // Called for every result word that the block hands over.
        function void check_verdict(logic found, logic overflow);
            t_verdict want;
            if (pending.size() == 0) begin
                err_cnt++;
                if (err_cnt <= REPORT_MAX) begin
                    $display("[%0t] unexpected result word: found=%b overflow=%b",
                             $realtime, found, overflow);
                end
                return;
            end
            want = pending.pop_front();
            if (want.found !== found || want.overflow !== overflow) begin
                err_cnt++;
                if (err_cnt <= REPORT_MAX) begin
                    $display({"[%0t] result mismatch: expected found=%b overflow=%b, ",
                              "got found=%b overflow=%b"},
                             $realtime, want.found, want.overflow, found, overflow);
                end
            end
        endfunction
    endclass

    logic  i_clk              = 1'b0;
    logic  i_rst_n            = 1'b0;
    logic  i_valid            = 1'b0;
    logic  i_req_type         = REQ_PATTERN;
    logic  i_has_value        = 1'b0;
    t_word i_element_value    = '0;
    logic  i_is_last          = 1'b0;
    logic  i_ready            = 1'b0;
    logic  o_ready;
    logic  o_valid;
    logic  o_found;
    logic  o_pattern_overflow;

    t_search_verdict_model verdicts;
    int    words_sent = 0;
    int    cycle_cnt  = 0;
    bit    steady_in  = 1'b0;
    t_word alphabet[$];
    t_word cur_pattern[$];

    contiguous_sequence_matcher i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_req_type         (i_req_type),
        .i_has_value        (i_has_value),
        .i_element_value    (i_element_value),
        .i_is_last          (i_is_last),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_found            (o_found),
        .o_pattern_overflow (o_pattern_overflow)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    // A word from the current alphabet, with the odd fully random one so that
    // near misses and arbitrary bit patterns both show up in the text.
    function automatic t_word pick_letter();
        if (alphabet.size() == 0 || $urandom_range(0, 15) == 0) begin
            return $urandom();
        end
        return alphabet[$urandom_range(0, alphabet.size() - 1)];
    endfunction

    // Presents one word at a falling edge, keeps it steady until the block
    // takes it at a rising edge, and tells the predictor about it. Outputs are
    // read right after the rising edge, before the block's registers update.
    task automatic offer_word(input logic req, input logic has_val, input t_word w,
                              input logic last);
        int gap;
        gap = steady_in ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_valid         <= 1'b0;
            i_element_value <= $urandom();
        end
        @(negedge i_clk);
        i_valid         <= 1'b1;
        i_req_type      <= req;
        i_has_value     <= has_val;
        i_element_value <= w;
        i_is_last       <= last;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        verdicts.take_word(req, has_val, w, last);
        words_sent++;
    endtask

    // Streams one text. Most texts hold the current pattern, a prefix of it or
    // a copy with one bit flipped in its last word, surrounded by letters from
    // the same alphabet; a few carry empty words or a stray pattern word.
    task automatic run_text();
        t_word txt[$];
        t_word ins[$];
        int    n;
        int    pos;
        int    shape;
        bit    end_empty;
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
            txt.push_back(pick_letter());
        end
        shape = $urandom_range(0, 2);
        if (shape != 0) begin
            ins = cur_pattern;
            if (shape == 2 && ins.size() > 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    ins[ins.size()-1] = ins[ins.size()-1]
                                        ^ (t_word'(1) << $urandom_range(0, 31));
                end else begin
                    void'(ins.pop_back());
                end
            end
            pos = $urandom_range(0, txt.size());
            foreach (ins[j]) begin
                txt.insert(pos + j, ins[j]);
            end
        end
        if (txt.size() == 0) begin
            offer_word(REQ_TEXT, 1'b0, $urandom(), 1'b1);
            return;
        end
        end_empty = ($urandom_range(0, 9) == 0);
        foreach (txt[i]) begin
            if ($urandom_range(0, 19) == 0) begin
                offer_word(REQ_TEXT, 1'b0, $urandom(), 1'b0);
            end
            if ($urandom_range(0, 49) == 0) begin
                offer_word(REQ_PATTERN, 1'b1, pick_letter(), 1'(($urandom_range(0, 1))));
            end
            offer_word(REQ_TEXT, 1'b1, txt[i], (i == txt.size() - 1) && !end_empty);
        end
        if (end_empty) begin
            offer_word(REQ_TEXT, 1'b0, $urandom(), 1'b1);
        end
    endtask

    // Picks a fresh small alphabet and a pattern over it, then loads the
    // pattern. Lengths are mostly short, sometimes up to the capacity and now
    // and then beyond it. Empty pattern words, texts while the pattern is
    // still open and patterns left open on purpose are mixed in.
    task automatic load_pattern();
        int  k;
        int  r;
        int  len;
        bit  leave_open;
        k = $urandom_range(1, 4);
        alphabet.delete();
        for (int i = 0; i < k; i++) begin
            r = $urandom_range(0, 9);
            case (r)
                0: alphabet.push_back(32'h8000_0000);
                1: alphabet.push_back(32'h7FFF_FFFF);
                2: alphabet.push_back('1);
                3: alphabet.push_back('0);
                default: alphabet.push_back($urandom());
            endcase
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
            len = 0;
        end else if (r < 78) begin
            len = $urandom_range(1, 4);
        end else if (r < 92) begin
            len = $urandom_range(5, MAX_PAT);
        end else begin
            len = $urandom_range(MAX_PAT + 1, MAX_PAT + 4);
        end
        cur_pattern.delete();
        for (int i = 0; i < len; i++) begin
            cur_pattern.push_back(alphabet[$urandom_range(0, k - 1)]);
        end
        if (len == 0) begin
            offer_word(REQ_PATTERN, 1'b0, $urandom(), 1'b1);
            return;
        end
        leave_open = ($urandom_range(0, 14) == 0);
        foreach (cur_pattern[i]) begin
            if ($urandom_range(0, 19) == 0) begin
                offer_word(REQ_PATTERN, 1'b0, $urandom(), 1'b0);
            end
            if (i > 0 && $urandom_range(0, 24) == 0) begin
                run_text();
            end
            offer_word(REQ_PATTERN, 1'b1, cur_pattern[i], (i == len - 1) && !leave_open);
        end
    endtask

    // Result side: stalls of random length, and now and then a long stretch
    // with ready held high throughout.
    initial begin
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(20, 60)) begin
                    @(negedge i_clk);
                    i_ready <= 1'b1;
                end
            end else begin
                repeat (pick_gap()) begin
                    @(negedge i_clk);
                    i_ready <= 1'b0;
                end
                repeat ($urandom_range(1, 4)) begin
                    @(negedge i_clk);
                    i_ready <= 1'b1;
                end
            end
        end
    end

    // Every result word taken from the block is checked against the oldest
    // pending verdict.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            verdicts.check_verdict(o_found, o_pattern_overflow);
        end
    end

    initial begin
        int directed_cnt;
        verdicts = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Before any pattern has been loaded the pattern is empty, so a text matches.
        offer_word(REQ_TEXT, 1'b1, 32'h0000_0000, 1'b1);

        // Extreme words as the pattern, found behind a leading word.
        offer_word(REQ_PATTERN, 1'b1, 32'h8000_0000, 1'b0);
        offer_word(REQ_PATTERN, 1'b1, 32'h7FFF_FFFF, 1'b1);
        offer_word(REQ_TEXT, 1'b1, 32'hFFFF_FFFF, 1'b0);
        offer_word(REQ_TEXT, 1'b1, 32'h8000_0000, 1'b0);
        offer_word(REQ_TEXT, 1'b1, 32'h7FFF_FFFF, 1'b1);

        // An empty text against a non-empty pattern does not match.
        offer_word(REQ_TEXT, 1'b0, 32'hFFFF_FFFF, 1'b1);

        // A pattern word in the middle of a text opens a new pattern and
        // restarts the search; the text then runs while the pattern is open,
        // and the next pattern word appends to it.
        offer_word(REQ_TEXT, 1'b1, 32'h8000_0000, 1'b0);
        offer_word(REQ_PATTERN, 1'b1, 32'hFFFF_FFFF, 1'b0);
        offer_word(REQ_TEXT, 1'b1, 32'hFFFF_FFFF, 1'b1);
        offer_word(REQ_PATTERN, 1'b1, 32'h0000_0000, 1'b1);
        offer_word(REQ_TEXT, 1'b1, 32'hFFFF_FFFF, 1'b0);
        offer_word(REQ_TEXT, 1'b0, 32'h0000_0000, 1'b0);
        offer_word(REQ_TEXT, 1'b1, 32'h0000_0000, 1'b1);

        // An empty pattern matches even an empty text.
        offer_word(REQ_PATTERN, 1'b0, 32'h1234_5678, 1'b1);
        offer_word(REQ_TEXT, 1'b0, 32'h0000_0000, 1'b1);

        // One word more than the store holds flags overflow and never matches.
        for (int i = 0; i <= MAX_PAT; i++) begin
            offer_word(REQ_PATTERN, 1'b1, 32'h5A5A_0000 + i, i == MAX_PAT);
        end
        offer_word(REQ_TEXT, 1'b1, 32'h5A5A_0000, 1'b1);
        directed_cnt = words_sent;

        // Random part: well-formed pattern and text sequences with random
        // content, runs without input gaps, and bursts of arbitrary words.
        while (words_sent < directed_cnt + RANDOM_WORDS) begin
            steady_in = ($urandom_range(0, 4) == 0);
            load_pattern();
            repeat ($urandom_range(1, 4)) begin
                run_text();
            end
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 5)) begin
                    offer_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               $urandom(), 1'($urandom_range(0, 1)));
                end
            end
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (verdicts.pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (verdicts.err_cnt == 0 && verdicts.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
